### hdl/lkvc_pkg.sv
// Shared constants, codes and types of the LRU key/value cache.
package lkvc_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_W    = 20;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned AGE_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned TAG_W    = KEY_W + AGE_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
    logic [KEY_W-1:0] ref_key;
    logic             have_best;
    logic [AGE_W-1:0] best_age;
    logic             bump_all;
    logic [AGE_W-1:0] thr_age;
  } ent_ctx_t;

  typedef struct packed {
    logic             match;
    logic             older;
    logic             is_free;
    logic             bump;
    logic [AGE_W-1:0] age_inc;
  } ent_flags_t;

endpackage

### hdl/lkvc_in_if.sv
// Input channel of the LRU key/value cache: one request transaction.
interface lkvc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lkvc_pkg::KIND_W-1:0]  kind;
  logic [lkvc_pkg::KEY_W-1:0]   key;
  logic [lkvc_pkg::VALUE_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink (input valid, kind, key, value, output ready);
endinterface

### hdl/lkvc_out_if.sv
// Output channel of the LRU key/value cache: one result transaction.
interface lkvc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [lkvc_pkg::VALUE_W-1:0] read_value;
  logic                        evicted;
  logic [lkvc_pkg::KEY_W-1:0]   evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

### hdl/lkvc_ram.sv
// Generic memory with one write port and one registered read port.
module lkvc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

### hdl/lkvc_entry_unit.sv
// Shared per-entry compare and age unit used on every step of both scans.
module lkvc_entry_unit (
  input  lkvc_pkg::ent_ctx_t   ctx_i,
  output lkvc_pkg::ent_flags_t flags_o
);

  always_comb begin
    flags_o.match   = ctx_i.valid && (ctx_i.key == ctx_i.ref_key);
    flags_o.older   = ctx_i.valid && (!ctx_i.have_best || (ctx_i.age > ctx_i.best_age));
    flags_o.is_free = !ctx_i.valid;
    flags_o.bump    = ctx_i.valid && (ctx_i.bump_all || (ctx_i.age < ctx_i.thr_age));
    flags_o.age_inc = ctx_i.age + 1'b1;
  end

endmodule

### hdl/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key/value cache.
//
// One request transaction enters on in_i (kind, key, value) and exactly one
// result transaction leaves on out_o (hit, read_value, evicted, evicted_key).
// Keys and recency ranks sit in one memory and values in another, and a
// single compare unit walks all CAPACITY entries one per cycle.
// An insert or a lookup first scans every entry to find the key, a free slot
// and the least recent entry; an insert or a lookup hit then makes a second
// pass that rewrites the ranks, while a lookup miss ends after the scan. A
// clear or an unused kind goes straight to the result.
// in_i.ready is high only while the block is idle, so one transaction is in
// work at a time. A finished result waits in an output register while the
// next request is taken; if the receiver still stalls when the following
// result is ready, the block holds it and stays busy until out_o is taken.
// Reset empties the cache at once by clearing the valid bits and the entry
// count; no clearing pass is needed.
module lru_key_value_cache_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  lkvc_in_if.sink       in_i,
  lkvc_out_if.source    out_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_AGE    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [lkvc_pkg::IDX_W-1:0] LastIdx = lkvc_pkg::IDX_W'(lkvc_pkg::CAPACITY - 1);
  localparam logic [lkvc_pkg::CNT_W-1:0] FullCnt = lkvc_pkg::CNT_W'(lkvc_pkg::CAPACITY);

  logic [2:0]                       state_q;
  logic [lkvc_pkg::CAPACITY-1:0]    valid_q;
  logic [lkvc_pkg::CNT_W-1:0]       count_q;
  lkvc_pkg::kind_e                  kind_q;
  logic [lkvc_pkg::KEY_W-1:0]       key_q;
  logic [lkvc_pkg::VALUE_W-1:0]     value_q;
  logic [lkvc_pkg::IDX_W-1:0]       idx_q;
  logic                             iss_q;
  logic                             pend_vld_q;
  logic [lkvc_pkg::IDX_W-1:0]       pend_idx_q;
  logic                             found_q;
  logic [lkvc_pkg::IDX_W-1:0]       slot_q;
  logic [lkvc_pkg::AGE_W-1:0]       thr_age_q;
  logic                             have_best_q;
  logic [lkvc_pkg::AGE_W-1:0]       best_age_q;
  logic [lkvc_pkg::IDX_W-1:0]       old_idx_q;
  logic [lkvc_pkg::KEY_W-1:0]       old_key_q;
  logic                             free_found_q;
  logic [lkvc_pkg::IDX_W-1:0]       free_idx_q;
  logic                             bump_all_q;
  logic                             res_hit_q;
  logic [lkvc_pkg::VALUE_W-1:0]     res_value_q;
  logic                             res_evicted_q;
  logic [lkvc_pkg::KEY_W-1:0]       res_evk_q;
  logic                             out_valid_q;
  logic                             out_hit_q;
  logic [lkvc_pkg::VALUE_W-1:0]     out_value_q;
  logic                             out_evicted_q;
  logic [lkvc_pkg::KEY_W-1:0]       out_evk_q;

  logic [lkvc_pkg::TAG_W-1:0]       tag_rdata;
  logic [lkvc_pkg::TAG_W-1:0]       tag_wdata;
  logic                             tag_we;
  logic [lkvc_pkg::VALUE_W-1:0]     val_rdata;
  logic                             val_we;
  logic [lkvc_pkg::KEY_W-1:0]       ent_key;
  logic [lkvc_pkg::AGE_W-1:0]       ent_age;
  logic                             at_slot;
  logic                             in_fire;
  logic                             out_free;
  lkvc_pkg::ent_ctx_t               ctx;
  lkvc_pkg::ent_flags_t             flags;

  assign ent_key = tag_rdata[lkvc_pkg::TAG_W-1:lkvc_pkg::AGE_W];
  assign ent_age = tag_rdata[lkvc_pkg::AGE_W-1:0];
  assign at_slot = (pend_idx_q == slot_q);

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.read_value  = out_value_q;
  assign out_o.evicted     = out_evicted_q;
  assign out_o.evicted_key = out_evk_q;

  always_comb begin
    ctx.valid     = valid_q[pend_idx_q];
    ctx.key       = ent_key;
    ctx.age       = ent_age;
    ctx.ref_key   = key_q;
    ctx.have_best = have_best_q;
    ctx.best_age  = best_age_q;
    ctx.bump_all  = bump_all_q;
    ctx.thr_age   = thr_age_q;
  end

  lkvc_entry_unit u_entry (
    .ctx_i   (ctx),
    .flags_o (flags)
  );

  assign tag_we    = (state_q == ST_AGE) && pend_vld_q && (at_slot || flags.bump);
  assign tag_wdata = at_slot ? {key_q, lkvc_pkg::AGE_W'(0)} : {ent_key, flags.age_inc};
  assign val_we    = (state_q == ST_AGE) && (kind_q == lkvc_pkg::KIND_INSERT);

  lkvc_ram #(
    .Width (lkvc_pkg::TAG_W),
    .Depth (lkvc_pkg::CAPACITY)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .wr_en_i   (tag_we),
    .wr_addr_i (pend_idx_q),
    .wr_data_i (tag_wdata),
    .rd_addr_i (idx_q),
    .rd_data_o (tag_rdata)
  );

  lkvc_ram #(
    .Width (lkvc_pkg::VALUE_W),
    .Depth (lkvc_pkg::CAPACITY)
  ) u_val_ram (
    .clk_i     (clk_i),
    .wr_en_i   (val_we),
    .wr_addr_i (slot_q),
    .wr_data_i (value_q),
    .rd_addr_i (slot_q),
    .rd_data_o (val_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= lkvc_pkg::kind_e'(in_i.kind);
      key_q   <= in_i.key;
      value_q <= in_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      valid_q       <= '0;
      count_q       <= '0;
      idx_q         <= '0;
      iss_q         <= 1'b0;
      pend_vld_q    <= 1'b0;
      pend_idx_q    <= '0;
      found_q       <= 1'b0;
      slot_q        <= '0;
      thr_age_q     <= '0;
      have_best_q   <= 1'b0;
      best_age_q    <= '0;
      old_idx_q     <= '0;
      old_key_q     <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      bump_all_q    <= 1'b0;
      res_hit_q     <= 1'b0;
      res_value_q   <= '0;
      res_evicted_q <= 1'b0;
      res_evk_q     <= '0;
      out_valid_q   <= 1'b0;
      out_hit_q     <= 1'b0;
      out_value_q   <= '0;
      out_evicted_q <= 1'b0;
      out_evk_q     <= '0;
    end else begin
      pend_vld_q <= (state_q inside {ST_SCAN, ST_AGE}) && iss_q;
      pend_idx_q <= idx_q;
      if (state_q inside {ST_SCAN, ST_AGE}) begin
        if (iss_q) begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == LastIdx) begin
            iss_q <= 1'b0;
          end
        end
      end

      if (out_valid_q && out_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            found_q       <= 1'b0;
            have_best_q   <= 1'b0;
            free_found_q  <= 1'b0;
            res_hit_q     <= 1'b0;
            res_value_q   <= '0;
            res_evicted_q <= 1'b0;
            res_evk_q     <= '0;
            idx_q         <= '0;
            case (lkvc_pkg::kind_e'(in_i.kind))
              lkvc_pkg::KIND_INSERT, lkvc_pkg::KIND_LOOKUP: begin
                iss_q   <= 1'b1;
                state_q <= ST_SCAN;
              end
              lkvc_pkg::KIND_CLEAR: begin
                valid_q <= '0;
                count_q <= '0;
                state_q <= ST_DONE;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (pend_vld_q) begin
            if (flags.match) begin
              found_q   <= 1'b1;
              slot_q    <= pend_idx_q;
              thr_age_q <= ent_age;
            end
            if (flags.older) begin
              have_best_q <= 1'b1;
              best_age_q  <= ent_age;
              old_idx_q   <= pend_idx_q;
              old_key_q   <= ent_key;
            end
            if (flags.is_free && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= pend_idx_q;
            end
            if (pend_idx_q == LastIdx) begin
              state_q <= ST_DECIDE;
            end
          end
        end

        ST_DECIDE: begin
          idx_q      <= '0;
          iss_q      <= 1'b1;
          bump_all_q <= 1'b0;
          state_q    <= ST_AGE;
          if (found_q) begin
            res_hit_q <= 1'b1;
          end else if (kind_q == lkvc_pkg::KIND_LOOKUP) begin
            iss_q   <= 1'b0;
            state_q <= ST_DONE;
          end else if (count_q == FullCnt) begin
            res_evicted_q <= 1'b1;
            res_evk_q     <= old_key_q;
            slot_q        <= old_idx_q;
            bump_all_q    <= 1'b1;
          end else begin
            slot_q     <= free_idx_q;
            bump_all_q <= 1'b1;
            count_q    <= count_q + 1'b1;
          end
        end

        ST_AGE: begin
          if (pend_vld_q && (pend_idx_q == LastIdx)) begin
            if (kind_q == lkvc_pkg::KIND_INSERT) begin
              valid_q[slot_q] <= 1'b1;
            end else begin
              res_value_q <= val_rdata;
            end
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_hit_q     <= res_hit_q;
            out_value_q   <= res_value_q;
            out_evicted_q <= res_evicted_q;
            out_evk_q     <= res_evk_q;
            state_q       <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
